[design/sdcb_pkg.sv]
// Package with widths, constants and stage types of the scale-degree chord builder.
`timescale 1ns / 1ps

package sdcb_pkg;

  localparam int unsigned PatternBits = 24;
  localparam int unsigned Degrees     = 12;
  localparam int unsigned DegreeBits  = 4;
  localparam int unsigned IndexBits   = 6;
  localparam int unsigned CountBits   = 5;
  localparam int unsigned InDataBits  = 24;
  localparam int unsigned OutDataBits = 40;
  localparam int unsigned OutUserBits = 2;

  localparam logic [PatternBits-1:0] PatternMask    = 24'hff_ffff;
  localparam logic [PatternBits-1:0] DefaultPattern = 24'h00_0091;
  localparam logic [IndexBits-1:0]   MajIndex       = 6'd7;
  localparam logic [DegreeBits-1:0]  LastDegree     = 4'(Degrees - 1);

  typedef enum logic {
    TableTriad   = 1'b0,
    TableSeventh = 1'b1
  } name_table_e;

  typedef struct packed {
    logic [PatternBits-1:0] rot;
    logic [DegreeBits-1:0]  degree;
    logic                   seventh_mode;
    logic                   present;
  } rot_stage_t;

  typedef struct packed {
    logic [PatternBits-1:0]                rot;
    logic [PatternBits-1:0][CountBits-1:0] cnt;
    logic [DegreeBits-1:0]                 degree;
    logic                                  seventh_mode;
    logic                                  present;
  } cnt_stage_t;

  typedef struct packed {
    logic [DegreeBits-1:0]  degree;
    logic [PatternBits-1:0] chord_pattern;
    name_table_e            name_table;
    logic [IndexBits-1:0]   name_index;
    logic                   used_default;
    logic                   last_degree;
  } result_t;

endpackage

[design/scale_degree_chord_builder_core.sv]
// Top level of the scale-degree chord builder: degree sequencer and three-stage pipeline.
// The input is registered in the degree sequencer; each degree then passes through the s1, s2 and out stages.
// The degree sequencer issues the twelve degrees of an item, one result per cycle while the output
//   is not stalled, and takes the next item with the last degree.
// A stalled output freezes every stage; nothing is lost or repeated.
// Reset (rst_ni low, asynchronous) clears all valid bits and the degree counter.
`timescale 1ns / 1ps

module scale_degree_chord_builder_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [23:0] scale_pattern
  input  logic [sdcb_pkg::InDataBits-1:0]     s_axis_tdata_i,
  // [0] seventh_mode
  input  logic                                s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [3:0] degree, [27:4] chord_pattern, [33:28] name_index, [39:34] zero
  output logic [sdcb_pkg::OutDataBits-1:0]    m_axis_tdata_o,
  // [0] name_table, [1] used_default
  output logic [sdcb_pkg::OutUserBits-1:0]    m_axis_tuser_o,
  output logic                                m_axis_tlast_o
);
  import sdcb_pkg::*;

  logic                   adv;
  logic                   in_xfer;
  logic                   issue_last;

  logic                   hold_valid_q, hold_valid_d;
  logic [PatternBits-1:0] scale_q, scale_d;
  logic                   mode_q, mode_d;
  logic [DegreeBits-1:0]  deg_q, deg_d;

  logic                   s1_valid_q;
  rot_stage_t             s1_q, s1_d;
  logic                   s2_valid_q;
  cnt_stage_t             s2_q, s2_d;
  logic                   out_valid_q;
  result_t                out_q, out_d;

  function automatic logic [PatternBits-1:0] prefix_mask(int unsigned pos);
    logic [PatternBits-1:0] m;
    m = PatternMask >> (PatternBits - 1 - pos);
    return m;
  endfunction

  assign adv             = !out_valid_q || m_axis_tready_i;
  assign issue_last      = (deg_q == LastDegree);
  assign s_axis_tready_o = adv && (!hold_valid_q || issue_last);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  // degree sequencer
  always_comb begin
    hold_valid_d = hold_valid_q;
    scale_d      = scale_q;
    mode_d       = mode_q;
    deg_d        = deg_q;
    if (adv) begin
      if (hold_valid_q && !issue_last) begin
        deg_d = deg_q + 4'd1;
      end else begin
        hold_valid_d = in_xfer;
        deg_d        = '0;
        if (in_xfer) begin
          scale_d = s_axis_tdata_i & PatternMask;
          mode_d  = s_axis_tuser_i;
        end
      end
    end
  end

  // stage 1: rotate so the degree lands on bit 0
  always_comb begin
    logic [2*PatternBits-1:0] dbl;
    dbl             = {scale_q, scale_q} >> deg_q;
    s1_d.rot        = dbl[PatternBits-1:0];
    s1_d.degree     = deg_q;
    s1_d.seventh_mode = mode_q;
    s1_d.present    = scale_q[deg_q];
  end

  // stage 2: running count of set bits at every position
  always_comb begin
    s2_d.rot          = s1_q.rot;
    s2_d.degree       = s1_q.degree;
    s2_d.seventh_mode = s1_q.seventh_mode;
    s2_d.present      = s1_q.present;
    for (int unsigned i = 0; i < PatternBits; i++) begin
      s2_d.cnt[i] = CountBits'($countones(s1_q.rot & prefix_mask(i)));
    end
  end

  // stage 3: classify intervals and build the result
  always_comb begin
    logic [PatternBits-1:0] h3, h5, h7;
    logic [1:0]             c3, c5, c7;
    logic                   v3, v5, v7;
    logic [3:0]             triad;
    logic [IndexBits-1:0]   sev;
    for (int unsigned i = 0; i < PatternBits; i++) begin
      h3[i] = s2_q.rot[i] && (s2_q.cnt[i] == 5'd3);
      h5[i] = s2_q.rot[i] && (s2_q.cnt[i] == 5'd5);
      h7[i] = s2_q.rot[i] && (s2_q.cnt[i] == 5'd7);
    end
    v3    = |h3[5:2];
    c3    = {h3[4] | h3[5], h3[3] | h3[5]};
    v5    = |h5[8:6];
    c5    = {h5[8], h5[7]};
    v7    = |h7[11:9];
    c7    = {h7[11], h7[10]};
    triad = {2'b00, c3} * 4'd3 + {2'b00, c5};
    sev   = {2'b00, triad} * 6'd3 + {4'b0000, c7};

    out_d.degree      = s2_q.degree;
    out_d.last_degree = (s2_q.degree == LastDegree);
    if (s2_q.present && v3 && v5) begin
      out_d.used_default  = 1'b0;
      out_d.chord_pattern = 24'd1 | h3 | h5 | (s2_q.seventh_mode ? h7 : '0);
      if (s2_q.seventh_mode && v7) begin
        out_d.name_table = TableSeventh;
        out_d.name_index = sev;
      end else begin
        out_d.name_table = TableTriad;
        out_d.name_index = {2'b00, triad};
      end
    end else begin
      out_d.used_default  = 1'b1;
      out_d.chord_pattern = DefaultPattern;
      out_d.name_table    = TableTriad;
      out_d.name_index    = MajIndex;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      deg_q        <= '0;
      s1_valid_q   <= 1'b0;
      s2_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else if (adv) begin
      hold_valid_q <= hold_valid_d;
      deg_q        <= deg_d;
      s1_valid_q   <= hold_valid_q;
      s2_valid_q   <= s1_valid_q;
      out_valid_q  <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      scale_q <= scale_d;
      mode_q  <= mode_d;
      s1_q    <= s1_d;
      s2_q    <= s2_d;
      out_q   <= out_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b000000, out_q.name_index, out_q.chord_pattern, out_q.degree};
  assign m_axis_tuser_o  = {out_q.used_default, out_q.name_table};
  assign m_axis_tlast_o  = out_q.last_degree;

endmodule

[design/sdcb_checker.sv]
// Port-level checker for the scale-degree chord builder and its bind.
`timescale 1ns / 1ps

module sdcb_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  input  logic [sdcb_pkg::OutDataBits-1:0] m_axis_tdata_o,
  input  logic [sdcb_pkg::OutUserBits-1:0] m_axis_tuser_o,
  input  logic                             m_axis_tlast_o
);
  import sdcb_pkg::*;

  a_last_on_final_degree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ((m_axis_tdata_o[3:0] == LastDegree) == m_axis_tlast_o))
    else $error("tlast does not match the final degree");

  a_default_chord: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[1]) |->
      (m_axis_tdata_o[27:4] == DefaultPattern && m_axis_tdata_o[33:28] == MajIndex
       && !m_axis_tuser_o[0]))
    else $error("fallback result is not the default maj chord");

  a_root_in_chord: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o[1]) |-> m_axis_tdata_o[4])
    else $error("built chord lacks its root");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))
    else $error("stalled output transfer changed");

endmodule

bind scale_degree_chord_builder_core sdcb_checker u_sdcb_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
